// ----- design/sds_pkg.sv -----
package sds_pkg;

  // 8.3 name layout
  localparam int unsigned NAME_LEN = 11;
  localparam int unsigned BASE_LEN = 8;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned CNT_W    = 13;
  localparam int unsigned IDX_W    = 12;

  localparam logic [7:0] SPACE_CHAR     = 8'h20;
  localparam logic [7:0] PERIOD_CHAR    = 8'h2E;
  localparam logic [7:0] LOWER_A        = 8'h61;
  localparam logic [7:0] LOWER_Z        = 8'h7A;
  localparam logic [7:0] CASE_OFFSET    = 8'h20;
  localparam logic [7:0] ATTR_SKIP_MASK = 8'h18;

  localparam logic [CNT_W-1:0] MAX_ENTRIES_RESET = 13'd224;

  // packed so that byte 0 sits in bits 7:0, matching the entry layout
  typedef logic [NAME_LEN-1:0][7:0] pattern_t;

  typedef enum logic [1:0] {
    MODE_START  = 2'd0,
    MODE_CHAR   = 2'd1,
    MODE_ENTRY  = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_CONTINUE  = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_NAME_BAD  = 2'd3
  } status_t;

  // one word moving from the input stage into the search state
  typedef struct packed {
    logic  fire;
    mode_t mode;
  } step_t;

endpackage

// ----- design/sds_pattern.sv -----
module sds_pattern
  import sds_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  step_t      step,
  input  logic [7:0] name_char,
  input  logic       decided,
  output pattern_t   pattern,
  output logic       overflow
);

  logic [POS_W-1:0] name_position;
  logic [POS_W-1:0] name_position_next;
  pattern_t         pattern_next;
  logic [7:0]       folded;
  logic             take;

  // upper-case fold of a-z
  always_comb begin
    if (name_char >= LOWER_A && name_char <= LOWER_Z) begin
      folded = name_char - CASE_OFFSET;
    end else begin
      folded = name_char;
    end
  end

  assign take     = step.fire && step.mode == MODE_CHAR && !decided && name_char != 8'h00;
  assign overflow = take && name_position >= POS_W'(NAME_LEN);

  // next pattern and position
  always_comb begin
    pattern_next       = pattern;
    name_position_next = name_position;
    if (step.fire && step.mode == MODE_START) begin
      pattern_next       = {NAME_LEN{SPACE_CHAR}};
      name_position_next = '0;
    end else if (take && !overflow) begin
      if (name_char == PERIOD_CHAR && name_position <= POS_W'(BASE_LEN)) begin
        name_position_next = POS_W'(BASE_LEN);
      end else begin
        for (int i = 0; i < NAME_LEN; i++) begin
          if (name_position == POS_W'(i)) begin
            pattern_next[i] = folded;
          end
        end
        name_position_next = name_position + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern       <= {NAME_LEN{SPACE_CHAR}};
      name_position <= '0;
    end else begin
      pattern       <= pattern_next;
      name_position <= name_position_next;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    name_position <= POS_W'(NAME_LEN))
    else $error("name position past end of pattern");

endmodule

// ----- design/sds_search.sv -----
module sds_search
  import sds_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  step_t            step,
  input  logic [63:0]      entry_name_base,
  input  logic [23:0]      entry_name_ext,
  input  logic [7:0]       entry_attr,
  input  logic [CNT_W-1:0] max_entries,
  input  pattern_t         pattern,
  input  logic             overflow,
  output logic             decided,
  output status_t          res_status,
  output logic [IDX_W-1:0] res_index
);

  logic [CNT_W-1:0] entries_seen;
  logic [CNT_W-1:0] entries_seen_next;
  logic             decided_next;
  status_t          held_status;
  status_t          held_status_next;
  logic [IDX_W-1:0] held_index;
  logic [IDX_W-1:0] held_index_next;
  logic             name_eq;
  logic             at_end;
  logic             entry_step;

  assign name_eq    = {entry_name_ext, entry_name_base} == pattern;
  assign at_end     = entries_seen >= max_entries || entry_name_base[7:0] == 8'h00;
  assign entry_step = step.fire && step.mode == MODE_ENTRY && !decided;

  // decision and entry counter
  always_comb begin
    entries_seen_next = entries_seen;
    decided_next      = decided;
    held_status_next  = held_status;
    held_index_next   = held_index;
    if (step.fire && step.mode == MODE_START) begin
      entries_seen_next = '0;
      decided_next      = 1'b0;
      held_status_next  = ST_CONTINUE;
      held_index_next   = '0;
    end else if (overflow) begin
      decided_next     = 1'b1;
      held_status_next = ST_NAME_BAD;
      held_index_next  = '0;
    end else if (entry_step) begin
      if (at_end) begin
        decided_next     = 1'b1;
        held_status_next = ST_NOT_FOUND;
        held_index_next  = '0;
      end else if ((entry_attr & ATTR_SKIP_MASK) == 8'h00 && name_eq) begin
        decided_next     = 1'b1;
        held_status_next = ST_FOUND;
        held_index_next  = entries_seen[IDX_W-1:0];
      end else begin
        entries_seen_next = entries_seen + CNT_W'(1);
      end
    end
  end

  // held values are zero while undecided, so their next values are the result directly
  assign res_status = held_status_next;
  assign res_index  = held_index_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_seen <= '0;
      decided      <= 1'b0;
      held_status  <= ST_CONTINUE;
      held_index   <= '0;
    end else begin
      entries_seen <= entries_seen_next;
      decided      <= decided_next;
      held_status  <= held_status_next;
      held_index   <= held_index_next;
    end
  end

  a_decided_status: assert property (@(posedge clk) disable iff (rst)
    decided == (held_status != ST_CONTINUE))
    else $error("decided flag disagrees with held status");

  a_index_only_found: assert property (@(posedge clk) disable iff (rst)
    held_status != ST_FOUND |-> held_index == '0)
    else $error("nonzero index without a match");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    decided && !(step.fire && step.mode == MODE_START) |=>
      decided && $stable(held_status) && $stable(held_index))
    else $error("decision changed without a new search");

endmodule

// ----- design/short_name_directory_search_top.sv -----
// channel | direction | handshake                  | payload
// in      | input     | in_valid / in_ready        | mode, name_char, entry_name_base,
//         |           |                            | entry_name_ext, entry_attr
// out     | output    | out_valid / out_ready      | status, entry_index
// cfg     | input     | cfg_valid / cfg_ready      | cfg_data (max_entries)
//
// One word per cycle unless out stalls; a word passes the input register, then the result register.
// The input register feeds the pattern/compare logic, which updates the search
// state and loads the result register in the same cycle.
// Reset (synchronous) gives max_entries 224, an all-space pattern, undecided.
// A stalled out channel holds the result and the input register; in_ready drops
// only while both are full. cfg_ready is always high.
module short_name_directory_search_top
  import sds_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       mode,
  input  logic [7:0]       name_char,
  input  logic [63:0]      entry_name_base,
  input  logic [23:0]      entry_name_ext,
  input  logic [7:0]       entry_attr,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       status,
  output logic [11:0]      entry_index,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [12:0]      cfg_data
);

  logic             stg_valid;
  mode_t            stg_mode;
  logic [7:0]       stg_char;
  logic [63:0]      stg_base;
  logic [23:0]      stg_ext;
  logic [7:0]       stg_attr;
  logic             adv;
  logic [CNT_W-1:0] max_entries;
  step_t            step;
  pattern_t         pattern;
  logic             overflow;
  logic             decided;
  status_t          res_status;
  logic [IDX_W-1:0] res_index;

  // config register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= MAX_ENTRIES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_entries <= cfg_data;
    end
  end

  // input register
  assign adv      = stg_valid && (!out_valid || out_ready);
  assign in_ready = !stg_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (in_ready) begin
      stg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_mode <= mode_t'(mode);
      stg_char <= name_char;
      stg_base <= entry_name_base;
      stg_ext  <= entry_name_ext;
      stg_attr <= entry_attr;
    end
  end

  assign step.fire = adv;
  assign step.mode = stg_mode;

  sds_pattern u_pattern (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .name_char (stg_char),
    .decided   (decided),
    .pattern   (pattern),
    .overflow  (overflow)
  );

  sds_search u_search (
    .clk             (clk),
    .rst             (rst),
    .step            (step),
    .entry_name_base (stg_base),
    .entry_name_ext  (stg_ext),
    .entry_attr      (stg_attr),
    .max_entries     (max_entries),
    .pattern         (pattern),
    .overflow        (overflow),
    .decided         (decided),
    .res_status      (res_status),
    .res_index       (res_index)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status      <= res_status;
      entry_index <= res_index;
    end
  end

  a_stage_kept: assert property (@(posedge clk) disable iff (rst)
    stg_valid && !adv |=> stg_valid)
    else $error("stalled word dropped from input register");

  a_take_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> stg_valid)
    else $error("accepted word not in input register");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import sds_pkg::*;

  localparam int STALL_LIMIT = 2000;

  // one input word as queued for the driver
  typedef struct {
    mode_t       md;
    logic [7:0]  ch;
    logic [63:0] base;
    logic [23:0] ext;
    logic [7:0]  attr;
  } dir_word_t;

  typedef struct {
    status_t          st;
    logic [IDX_W-1:0] idx;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        mode = '0;
  logic [7:0]        name_char = '0;
  logic [63:0]       entry_name_base = '0;
  logic [23:0]       entry_name_ext = '0;
  logic [7:0]        entry_attr = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        status;
  logic [11:0]       entry_index;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CNT_W-1:0]  cfg_data = '0;

  short_name_directory_search_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dir_word_t pending_words[$];
  verdict_t  due_verdicts[$];

  int  idle_pct = 0;
  int  stall_pct = 0;
  bit  hold_on = 1'b0;
  bit  in_took = 1'b0;
  bit  cfg_took = 1'b0;
  int  errors = 0;
  int  fed = 0;
  int  words_in = 0;
  int  n_checked = 0;
  int  n_found = 0;
  int  n_missing = 0;
  int  n_badname = 0;
  int  quiet = 0;

  // search state mirrored from the spec
  pattern_t          pat;
  logic [POS_W-1:0]  pos;
  logic [CNT_W-1:0]  seen;
  bit                done;
  status_t           hst;
  logic [IDX_W-1:0]  hidx;
  logic [CNT_W-1:0]  lim;

  task automatic note_error(input string msg);
    $display("tb: mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic clear_search();
    pat  = {NAME_LEN{SPACE_CHAR}};
    pos  = '0;
    seen = '0;
    done = 1'b0;
    hst  = ST_CONTINUE;
    hidx = '0;
  endtask

  // apply one word to the mirrored search state, return the expected result
  task automatic advance_search(input dir_word_t w, output verdict_t v);
    pattern_t   e;
    logic [7:0] c;
    e = {w.ext, w.base};
    c = w.ch;
    case (w.md)
      MODE_START: clear_search();
      MODE_CHAR: begin
        if (!done && c != 8'h00) begin
          if (pos >= NAME_LEN) begin
            done = 1'b1;
            hst  = ST_NAME_BAD;
            hidx = '0;
          end else if (c == PERIOD_CHAR && pos <= BASE_LEN) begin
            pos = POS_W'(BASE_LEN);
          end else begin
            if (c >= LOWER_A && c <= LOWER_Z) c = c - CASE_OFFSET;
            pat[pos] = c;
            pos = pos + 1'b1;
          end
        end
      end
      MODE_ENTRY: begin
        if (!done) begin
          if (seen >= lim || e[0] == 8'h00) begin
            done = 1'b1;
            hst  = ST_NOT_FOUND;
            hidx = '0;
          end else if ((w.attr & ATTR_SKIP_MASK) == 8'h00 && e == pat) begin
            done = 1'b1;
            hst  = ST_FOUND;
            hidx = seen[IDX_W-1:0];
          end else begin
            seen = seen + 1'b1;
          end
        end
      end
      default: ;
    endcase
    v.st  = done ? hst : ST_CONTINUE;
    v.idx = done ? hidx : '0;
  endtask

  // ---------------- stimulus helpers ----------------

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [7:0] upcase(input logic [7:0] c);
    return (c >= LOWER_A && c <= LOWER_Z) ? c - CASE_OFFSET : c;
  endfunction

  function automatic logic [7:0] pick_glyph();
    case ($urandom_range(4))
      0: return 8'h41 + 8'($urandom_range(25));
      1: return 8'h61 + 8'($urandom_range(25));
      2: return 8'h30 + 8'($urandom_range(9));
      3: return $urandom_range(1) ? 8'h5F : 8'h7E;
      default: return $urandom_range(1) ? 8'h2D : 8'h24;
    endcase
  endfunction

  task automatic put(input mode_t md, input logic [7:0] ch, input logic [63:0] b,
                     input logic [23:0] e, input logic [7:0] a);
    dir_word_t w;
    w.md = md;
    w.ch = ch;
    w.base = b;
    w.ext = e;
    w.attr = a;
    pending_words.push_back(w);
    if (md != MODE_UNUSED && !(md == MODE_CHAR && ch == 8'h00)) fed++;
  endtask

  task automatic put_start();
    put(MODE_START, 8'($urandom), rnd64(), 24'($urandom), 8'($urandom));
  endtask

  task automatic put_char(input logic [7:0] c);
    put(MODE_CHAR, c, rnd64(), 24'($urandom), 8'($urandom));
  endtask

  task automatic put_entry(input pattern_t q, input logic [7:0] a);
    put(MODE_ENTRY, 8'($urandom), q[BASE_LEN-1:0], q[NAME_LEN-1:BASE_LEN], a);
  endtask

  // one random name character, stray zero now and then
  task automatic name_glyph_at(inout pattern_t p, input int at);
    logic [7:0] c;
    c = pick_glyph();
    if ($urandom_range(9) == 0) put_char(8'h00);
    put_char(c);
    p[at] = upcase(c);
  endtask

  task automatic push_name(output pattern_t p);
    int blen, elen;
    p = {NAME_LEN{SPACE_CHAR}};
    blen = $urandom_range(1, BASE_LEN);
    elen = $urandom_range(0, NAME_LEN - BASE_LEN);
    for (int i = 0; i < blen; i++) name_glyph_at(p, i);
    if (elen != 0 || $urandom_range(1) == 1) put_char(PERIOD_CHAR);
    for (int i = 0; i < elen; i++) name_glyph_at(p, BASE_LEN + i);
  endtask

  // well-formed search: start, name, up to eight entries, maybe the match, up to two stray words
  task automatic push_search();
    pattern_t   p, q;
    logic [7:0] a;
    int         k;
    put_start();
    push_name(p);
    repeat ($urandom_range(0, 8)) begin
      q = p;
      a = 8'($urandom);
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          q = {24'($urandom), rnd64()};
          if (q[0] == 8'h00) q[0] = 8'hE5;
        end
        4, 5: begin
          // near miss on one bit of one byte
          k = $urandom_range(NAME_LEN - 1);
          q[k] = q[k] ^ (8'h01 << $urandom_range(7));
          a = a & ~ATTR_SKIP_MASK;
        end
        6: a = a | ($urandom_range(1) ? 8'h10 : 8'h08);
        7: q[0] = 8'h00;
        default: ;
      endcase
      put_entry(q, a);
    end
    if ($urandom_range(9) < 6) put_entry(p, 8'($urandom) & ~ATTR_SKIP_MASK);
    repeat ($urandom_range(0, 2))
      put(mode_t'($urandom_range(1, 3)), 8'($urandom), rnd64(), 24'($urandom),
          8'($urandom));
  endtask

  task automatic push_noise();
    if ($urandom_range(4) == 0) begin
      // name that runs past eleven characters
      put_start();
      repeat ($urandom_range(12, 14)) put_char(pick_glyph());
    end else begin
      repeat ($urandom_range(1, 4))
        put(mode_t'($urandom_range(3)), 8'($urandom), rnd64(), 24'($urandom),
            8'($urandom));
    end
  endtask

  task automatic fill(input int n);
    int goal;
    goal = fed + n;
    while (fed < goal) begin
      if ($urandom_range(9) < 8) push_search();
      else push_noise();
    end
  endtask

  // name "A", n entries that cannot match, then the match at index n
  task automatic push_long_scan(input int n);
    pattern_t pa, q;
    pa = {NAME_LEN{SPACE_CHAR}};
    pa[0] = 8'h41;
    put_start();
    put_char(8'h61);
    repeat (n) begin
      q = {24'($urandom), rnd64()};
      q[0] = 8'h42;
      put_entry(q, 8'($urandom));
    end
    put_entry(pa, 8'($urandom) & ~ATTR_SKIP_MASK);
  endtask

  // wait until every queued word went in and every result came back
  task automatic settle();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || due_verdicts.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(input logic [CNT_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(negedge clk);
    while (!cfg_took);
    cfg_valid <= 1'b0;
  endtask

  task automatic begin_phase(input logic [CNT_W-1:0] l, input int ipct, input int spct);
    settle();
    write_limit(l);
    @(posedge clk);
    idle_pct  = ipct;
    stall_pct = spct;
  endtask

  // ---------------- driver: input words ----------------
  always @(negedge clk) begin
    dir_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
        w = pending_words.pop_front();
        in_valid        <= 1'b1;
        mode            <= w.md;
        name_char       <= w.ch;
        entry_name_base <= w.base;
        entry_name_ext  <= w.ext;
        entry_attr      <= w.attr;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver backpressure
  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= !hold_on && ($urandom_range(99) >= stall_pct);
  end

  // ---------------- monitor: predict on accept, check results ----------------
  always @(posedge clk) begin
    dir_word_t cur;
    verdict_t  want;
    in_took  = in_valid && in_ready;
    cfg_took = cfg_valid && cfg_ready;
    if (rst) begin
      clear_search();
      lim = MAX_ENTRIES_RESET;
    end else begin
      if (cfg_took) lim = cfg_data;
      if (in_took) begin
        cur.md   = mode_t'(mode);
        cur.ch   = name_char;
        cur.base = entry_name_base;
        cur.ext  = entry_name_ext;
        cur.attr = entry_attr;
        advance_search(cur, want);
        due_verdicts.push_back(want);
        words_in++;
      end
      if (out_valid && out_ready) begin
        if (due_verdicts.size() == 0) begin
          note_error("result word with nothing expected");
        end else begin
          want = due_verdicts.pop_front();
          if (status !== want.st)
            note_error($sformatf("status %0d, expected %0d", status, want.st));
          if (entry_index !== want.idx)
            note_error($sformatf("entry_index %0d, expected %0d", entry_index, want.idx));
          n_checked++;
          case (want.st)
            ST_FOUND:     n_found++;
            ST_NOT_FOUND: n_missing++;
            ST_NAME_BAD:  n_badname++;
            default: ;
          endcase
        end
      end
    end
  end

  // watchdog: too long without any handshake
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet == STALL_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // ---------------- sequence of phases ----------------
  initial begin
    pattern_t pa;
    pa = {NAME_LEN{SPACE_CHAR}};
    pa[0] = 8'h41;
    pa[BASE_LEN] = 8'h5A;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // limit 2: folding, zero char, period jump, skipped attr, found, held result
    begin_phase(2, 0, 0);
    put_start();
    put_char(8'h61);
    put_char(8'h00);
    put_char(PERIOD_CHAR);
    put_char(8'h7A);
    put_entry(pa, 8'h08);
    put_entry(pa, 8'hE7);
    put_char(8'h62);
    put(MODE_UNUSED, 8'hFF, '1, '1, 8'hFF);
    // unused mode while undecided, extremes, then the limit
    put_start();
    put(MODE_UNUSED, 8'h00, '0, '0, 8'h00);
    put(MODE_ENTRY, 8'hFF, '1, '1, 8'hFF);
    put(MODE_ENTRY, 8'h00, 64'h1, 24'h0, 8'h00);
    put_entry(pa, 8'h00);

    // limit 0: first entry already over the limit
    begin_phase(0, 0, 0);
    put_start();
    put_entry(pa, 8'h00);

    // end-marker entry (first byte zero) ends the search; name too long
    begin_phase(4096, 0, 0);
    put_start();
    put(MODE_ENTRY, 8'h00, '0, '0, 8'h00);
    put_start();
    put_char(8'hFF);
    put_char(8'h01);
    repeat (6) put_char(pick_glyph());
    put_char(8'h78);
    put_char(PERIOD_CHAR);
    put_char(8'h79);
    put_char(PERIOD_CHAR);

    // random traffic under different limits and flow control
    begin_phase(MAX_ENTRIES_RESET, 0, 0);
    fill(300);
    begin_phase(7, 72, 0);
    fill(250);
    begin_phase(4096, 0, 72);
    fill(250);
    begin_phase(1, 22, 22);
    fill(250);

    // receiver holds off while the sender keeps pushing
    begin_phase(13, 0, 0);
    hold_on = 1'b1;
    fill(150);
    repeat (300) @(posedge clk);
    hold_on = 1'b0;

    // long scan: match found far past the small limits
    begin_phase({CNT_W{1'b1}}, 0, 0);
    push_long_scan(150);

    settle();
    repeat (8) @(posedge clk);
    if (due_verdicts.size() != 0)
      note_error($sformatf("%0d expected results never arrived", due_verdicts.size()));
    $display("tb: %0d words in, %0d results checked (%0d found, %0d not found, %0d bad name)",
             words_in, n_checked, n_found, n_missing, n_badname);
    $display("tb: limits 0 to 8191, idle and stall mixes, one long output hold-off");
    if (errors == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule
